// ----- src/fcmt_pkg.sv -----
// ----------------------------------------------------------------------------
// fcmt_pkg
// Types and constants shared by the motion tween block and its channels.
// ----------------------------------------------------------------------------
package fcmt_pkg;

   typedef enum logic [2:0] {
      MODE_TICK         = 3'd0,
      MODE_POS_TARGET   = 3'd1,
      MODE_SCALE_TARGET = 3'd2,
      MODE_SET_POS      = 3'd3,
      MODE_SET_SCALE    = 3'd4
   } mode_type;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANIM_ENABLED = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRAW_MODE    = 1'd1;

   localparam logic [1:0] DRAW_STATIC = 2'd0;
   localparam logic [1:0] DRAW_ROTATE = 2'd1;

   localparam logic [15:0] ANGLE_STEP = 16'h00B6;
   localparam logic [31:0] SCALE_ONE  = 32'h0001_0000;

   // channel slots: three axes, then the scale
   localparam int unsigned NUM_AXES  = 3;
   localparam int unsigned NUM_CHANS = 4;
   localparam int unsigned SCALE_CH  = 3;

endpackage

// ----- src/fcmt_req_if.sv -----
// ----------------------------------------------------------------------------
// fcmt_req_if
// Request channel: tick, target and direct-write items.
// ----------------------------------------------------------------------------
interface fcmt_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [31:0] target_z;
   logic signed [31:0] target_scale;
   logic signed [15:0] frame_count;

   modport source (output valid, mode, target_x, target_y, target_z, target_scale,
                   frame_count, input ready);
   modport sink (input valid, mode, target_x, target_y, target_z, target_scale,
                 frame_count, output ready);
endinterface

// ----- src/fcmt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fcmt_rsp_if
// Response channel: tween state after one step.
// ----------------------------------------------------------------------------
interface fcmt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] cur_scale;
   logic [15:0]        angle;
   logic signed [15:0] draw_scale;
   logic               moving;

   modport source (output valid, pos_x, pos_y, pos_z, cur_scale, angle, draw_scale,
                   moving, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, cur_scale, angle, draw_scale,
                 moving, output ready);
endinterface

// ----- src/fcmt_csr_if.sv -----
// ----------------------------------------------------------------------------
// fcmt_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface fcmt_csr_if
   import fcmt_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/frame_counted_motion_tween.sv -----
// ----------------------------------------------------------------------------
// frame_counted_motion_tween
// Tweens a 3-axis position and a 16.16 scale toward targets over frames.
// ----------------------------------------------------------------------------
//  channel  dir  transfer when       payload
//  req_if   in   valid & ready       mode, targets, frame_count
//  rsp_if   out  valid & ready       position, scale, angle, draw_scale, moving
//  csr_if   in   valid & ready       index, data (always ready)
//
//  With animation on, a tick is accepted, then bit-serial adds step each channel
//  whose frame count is positive one bit a cycle, then the result is loaded.
//  A target with a nonzero frame count runs the three bit-serial dividers side
//  by side. Other items, and ticks with animation off, go straight to the load.
//  Reset is synchronous; state returns to zero with the scale at 1.0.
//  A new item is taken while the last result waits; a finished result holds
//  until the response register frees up.
// ----------------------------------------------------------------------------
module frame_counted_motion_tween
   import fcmt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fcmt_req_if.sink   req_if,
   fcmt_rsp_if.source rsp_if,
   fcmt_csr_if.sink   csr_if
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_TICK,
      S_DONE
   } state_type;

   state_type   state_ff;

   logic [31:0] val_ff [NUM_CHANS];
   logic [31:0] vel_ff [NUM_CHANS];
   logic [15:0] cnt_ff [NUM_CHANS];
   logic [31:0] tgt_ff [NUM_CHANS];
   logic [NUM_CHANS-1:0] step_en_ff;
   logic [NUM_CHANS-1:0] carry_ff;
   logic [15:0] rotation_ff;
   logic [15:0] frames_ff;
   logic        scale_sel_ff;
   logic        div_start_ff;
   logic [4:0]  bit_cnt_ff;
   logic [15:0] draw_ff;

   logic        anim_enabled_ff;
   logic [1:0]  draw_mode_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_pos_ff [NUM_AXES];
   logic [31:0] rsp_scale_ff;
   logic [15:0] rsp_angle_ff;
   logic [15:0] rsp_draw_ff;
   logic        rsp_moving_ff;

   logic [31:0] lane_tgt_in [NUM_AXES];
   logic [31:0] lane_cur_in [NUM_AXES];
   logic [31:0] lane_quot   [NUM_AXES];
   logic [NUM_AXES-1:0] lane_done;

   logic [NUM_CHANS-1:0] positive_in;
   logic [31:0] req_tgt_in [NUM_CHANS];
   logic        req_xfer_in;
   logic        frames_zero_in;

   assign req_tgt_in[0]        = req_if.target_x;
   assign req_tgt_in[1]        = req_if.target_y;
   assign req_tgt_in[2]        = req_if.target_z;
   assign req_tgt_in[SCALE_CH] = req_if.target_scale;

   assign req_if.ready   = (state_ff == S_IDLE);
   assign req_xfer_in    = req_if.valid && req_if.ready;
   assign frames_zero_in = (req_if.frame_count == 16'sd0);
   assign csr_if.ready   = 1'b1;

   always_comb begin
      for (int i = 0; i < NUM_CHANS; i++) begin
         positive_in[i] = !cnt_ff[i][15] && (cnt_ff[i] != 16'd0);
      end
   end

   // lane 0 doubles as the scale divider
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         lane_tgt_in[i] = tgt_ff[i];
         lane_cur_in[i] = val_ff[i];
      end
      if (scale_sel_ff) begin
         lane_tgt_in[0] = tgt_ff[SCALE_CH];
         lane_cur_in[0] = val_ff[SCALE_CH];
      end
   end

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      fcmt_div u_div (
         .clock  (clock),
         .reset  (reset),
         .start  (div_start_ff),
         .target (lane_tgt_in[g]),
         .cur    (lane_cur_in[g]),
         .frames (frames_ff),
         .done   (lane_done[g]),
         .quot   (lane_quot[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anim_enabled_ff <= 1'b0;
         draw_mode_ff    <= DRAW_STATIC;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_ANIM_ENABLED: anim_enabled_ff <= csr_if.data[0];
            CSR_DRAW_MODE:    draw_mode_ff    <= csr_if.data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rotation_ff  <= '0;
         for (int i = 0; i < NUM_CHANS; i++) begin
            val_ff[i] <= (i == SCALE_CH) ? SCALE_ONE : '0;
            vel_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         div_start_ff <= req_xfer_in && !frames_zero_in &&
                         (req_if.mode == MODE_POS_TARGET ||
                          req_if.mode == MODE_SCALE_TARGET);
         // a result loaded in S_DONE takes over the register this cycle
         if (rsp_valid_ff && rsp_if.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer_in) begin
                  draw_ff   <= {val_ff[SCALE_CH][18:8], 5'd0};
                  frames_ff <= req_if.frame_count;
                  for (int i = 0; i < NUM_CHANS; i++) begin
                     tgt_ff[i] <= req_tgt_in[i];
                  end
                  unique case (mode_type'(req_if.mode))
                     MODE_TICK: begin
                        if (anim_enabled_ff) begin
                           if (draw_mode_ff == DRAW_STATIC) begin
                              rotation_ff <= '0;
                           end else if (draw_mode_ff == DRAW_ROTATE &&
                                        cnt_ff[SCALE_CH] != 16'd0) begin
                              rotation_ff <= rotation_ff + ANGLE_STEP;
                           end
                           for (int i = 0; i < NUM_CHANS; i++) begin
                              if (positive_in[i]) begin
                                 cnt_ff[i] <= cnt_ff[i] - 16'd1;
                              end
                           end
                           step_en_ff <= positive_in;
                           carry_ff   <= '0;
                           bit_cnt_ff <= '0;
                           state_ff   <= S_TICK;
                        end else begin
                           val_ff[SCALE_CH] <= SCALE_ONE;
                           vel_ff[SCALE_CH] <= '0;
                           cnt_ff[SCALE_CH] <= '0;
                           rotation_ff      <= '0;
                           state_ff         <= S_DONE;
                        end
                     end
                     MODE_POS_TARGET: begin
                        for (int i = 0; i < NUM_AXES; i++) begin
                           cnt_ff[i] <= req_if.frame_count;
                           if (frames_zero_in) begin
                              vel_ff[i] <= '0;
                              val_ff[i] <= req_tgt_in[i];
                           end
                        end
                        if (!frames_zero_in) begin
                           scale_sel_ff <= 1'b0;
                           state_ff     <= S_DIV;
                        end else begin
                           state_ff <= S_DONE;
                        end
                     end
                     MODE_SCALE_TARGET: begin
                        cnt_ff[SCALE_CH] <= req_if.frame_count;
                        if (frames_zero_in) begin
                           vel_ff[SCALE_CH] <= '0;
                           val_ff[SCALE_CH] <= req_tgt_in[SCALE_CH];
                           state_ff         <= S_DONE;
                        end else begin
                           scale_sel_ff <= 1'b1;
                           state_ff     <= S_DIV;
                        end
                     end
                     MODE_SET_POS: begin
                        for (int i = 0; i < NUM_AXES; i++) begin
                           val_ff[i] <= req_tgt_in[i];
                        end
                        state_ff <= S_DONE;
                     end
                     MODE_SET_SCALE: begin
                        val_ff[SCALE_CH] <= req_tgt_in[SCALE_CH];
                        state_ff         <= S_DONE;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_DIV: begin
               if (&lane_done) begin
                  if (scale_sel_ff) begin
                     vel_ff[SCALE_CH] <= lane_quot[0];
                  end else begin
                     for (int i = 0; i < NUM_AXES; i++) begin
                        vel_ff[i] <= lane_quot[i];
                     end
                  end
                  state_ff <= S_DONE;
               end
            end
            S_TICK: begin
               // one sum bit a cycle into the top; velocity rotates back in place
               for (int i = 0; i < NUM_CHANS; i++) begin
                  vel_ff[i] <= {vel_ff[i][0], vel_ff[i][31:1]};
                  if (step_en_ff[i]) begin
                     val_ff[i]   <= {val_ff[i][0] ^ vel_ff[i][0] ^ carry_ff[i],
                                     val_ff[i][31:1]};
                     carry_ff[i] <= (val_ff[i][0] & vel_ff[i][0]) |
                                    (carry_ff[i] & (val_ff[i][0] ^ vel_ff[i][0]));
                  end
               end
               bit_cnt_ff <= bit_cnt_ff + 5'd1;
               if (bit_cnt_ff == 5'd31) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // hold until the response register is free
               if (!rsp_valid_ff || rsp_if.ready) begin
                  for (int i = 0; i < NUM_AXES; i++) begin
                     rsp_pos_ff[i] <= val_ff[i];
                  end
                  rsp_scale_ff  <= val_ff[SCALE_CH];
                  rsp_angle_ff  <= rotation_ff;
                  rsp_draw_ff   <= draw_ff;
                  rsp_moving_ff <= |positive_in;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pos_x      = rsp_pos_ff[0];
   assign rsp_if.pos_y      = rsp_pos_ff[1];
   assign rsp_if.pos_z      = rsp_pos_ff[2];
   assign rsp_if.cur_scale  = rsp_scale_ff;
   assign rsp_if.angle      = rsp_angle_ff;
   assign rsp_if.draw_scale = rsp_draw_ff;
   assign rsp_if.moving     = rsp_moving_ff;

endmodule

// ----- src/fcmt_div.sv -----
// ----------------------------------------------------------------------------
// fcmt_div
// Bit-serial signed divider: (target - cur) / frames, truncated toward zero.
// One quotient bit per cycle through a shift register, after an absolute-value step and before a sign fix.
// ----------------------------------------------------------------------------
module fcmt_div
   import fcmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] target,
   input  logic [31:0] cur,
   input  logic [15:0] frames,
   output logic        done,
   output logic [31:0] quot
);

   typedef enum logic [1:0] {
      D_IDLE,
      D_ABS,
      D_RUN,
      D_FIX
   } div_state_type;

   div_state_type state_ff;
   logic [31:0]   diff_ff;
   logic [31:0]   q_ff;
   logic [15:0]   rem_ff;
   logic [16:0]   den_ff;
   logic          fneg_ff;
   logic          neg_ff;
   logic [4:0]    cnt_ff;
   logic          done_ff;

   logic [16:0]   trial_in;
   logic          ge_in;
   logic [16:0]   fext_in;

   assign fext_in  = {frames[15], frames};
   assign trial_in = {rem_ff, q_ff[31]};
   assign ge_in    = (trial_in >= den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == D_FIX);
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  diff_ff  <= target - cur;
                  den_ff   <= frames[15] ? (17'd0 - fext_in) : fext_in;
                  fneg_ff  <= frames[15];
                  state_ff <= D_ABS;
               end
            end
            D_ABS: begin
               neg_ff   <= diff_ff[31] ^ fneg_ff;
               q_ff     <= diff_ff[31] ? (32'd0 - diff_ff) : diff_ff;
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= D_RUN;
            end
            D_RUN: begin
               // shift in one dividend bit, restore when the trial falls short
               rem_ff <= ge_in ? 16'(trial_in - den_ff) : trial_in[15:0];
               q_ff   <= {q_ff[30:0], ge_in};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= D_FIX;
               end
            end
            D_FIX: begin
               q_ff     <= neg_ff ? (32'd0 - q_ff) : q_ff;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
